>>> rtl/hkrd_pkg.sv
// Package for the HID keyboard report differ: shared types, codes and the
// US ASCII key map. No dependencies; used by every module under rtl.
`default_nettype none
package hkrd_pkg;

	localparam int NUM_SLOTS  = 6;
	localparam int FIFO_DEPTH = 128;
	localparam int NUM_EVT    = 2 * NUM_SLOTS;

	localparam logic [7:0] SHIFT_MASK = 8'h22;

	localparam logic [1:0] KIND_PRESS   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	typedef logic [NUM_SLOTS-1:0][7:0] keys_t;

	typedef struct packed {
		logic       press;
		logic       release_;
		logic [6:0] ch;
	} lane_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	function automatic logic [6:0] map_key(input logic [7:0] code, input logic shifted);
		logic [6:0] ch;
		ch = 7'h00;
		if (code inside {[8'd4:8'd29]}) begin
			ch = (shifted ? 7'h41 : 7'h61) + (code[6:0] - 7'd4);
		end else begin
			case (code)
				8'd30: ch = shifted ? 7'h21 : 7'h31;
				8'd31: ch = shifted ? 7'h40 : 7'h32;
				8'd32: ch = shifted ? 7'h23 : 7'h33;
				8'd33: ch = shifted ? 7'h24 : 7'h34;
				8'd34: ch = shifted ? 7'h25 : 7'h35;
				8'd35: ch = shifted ? 7'h5E : 7'h36;
				8'd36: ch = shifted ? 7'h26 : 7'h37;
				8'd37: ch = shifted ? 7'h2A : 7'h38;
				8'd38: ch = shifted ? 7'h28 : 7'h39;
				8'd39: ch = shifted ? 7'h29 : 7'h30;
				8'd40: ch = 7'h0A;
				8'd42: ch = 7'h08;
				8'd43: ch = 7'h09;
				8'd44: ch = 7'h20;
				8'd45: ch = shifted ? 7'h5F : 7'h2D;
				8'd46: ch = shifted ? 7'h2B : 7'h3D;
				8'd47: ch = shifted ? 7'h7B : 7'h5B;
				8'd48: ch = shifted ? 7'h7D : 7'h5D;
				8'd49: ch = shifted ? 7'h7C : 7'h5C;
				8'd51: ch = shifted ? 7'h3A : 7'h3B;
				8'd52: ch = shifted ? 7'h22 : 7'h27;
				8'd53: ch = shifted ? 7'h7E : 7'h60;
				8'd54: ch = shifted ? 7'h3C : 7'h2C;
				8'd55: ch = shifted ? 7'h3E : 7'h2E;
				8'd56: ch = shifted ? 7'h3F : 7'h2F;
				default: ch = 7'h00;
			endcase
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

>>> rtl/hid_keyboard_report_differ.sv
// Top level of the HID keyboard report differ: slot lanes, event sequencer
// and output register. Depends on hkrd_pkg, hkrd_lane and hkrd_char_fifo.
//
// channel  | dir | handshake        | payload
// s_       | in  | s_tvalid/tready  | tdata: modifiers, key0..key5; tuser: action
// m_       | out | m_tvalid/tready  | tdata: keycode, character, char_available;
//          |     |                  | tuser: event_kind; tlast: last
// cfg_     | in  | cfg_wr_en        | cfg_wr_data: events_enable
//
// A report yields one event per press or release (up to 12), one event per
// cycle from the sequencer while the output register is not stalled.
// Reset clears the previous key set, FIFO pointers and events_enable; no clearing pass.
// While events_enable is set, a stalled output register holds the sequencer; input is taken only when idle.
`default_nettype none
module hid_keyboard_report_differ #(
	parameter int FIFO_DEPTH = hkrd_pkg::FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // modifiers, key0, key1, key2, key3, key4, key5
	input  wire logic        s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,  // keycode, character, char_available
	output logic       [1:0] m_tuser,  // event_kind
	output logic             m_tlast,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data
);

	localparam int NS = hkrd_pkg::NUM_SLOTS;
	localparam int NE = hkrd_pkg::NUM_EVT;
	localparam int IW = $clog2(NE);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	logic [1:0]           state_q;
	logic                 en_q;
	logic                 shift_q;
	hkrd_pkg::keys_t      keys_q;
	hkrd_pkg::keys_t      prev_q;
	logic [NE-1:0]        pend_q;
	hkrd_pkg::lane_t      lanes [NS];
	logic [NE-1:0]        flags;

	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [7:0]           out_code_q;
	logic [6:0]           out_char_q;
	logic                 out_avail_q;
	logic                 out_last_q;

	logic                 slot_free;
	logic [IW-1:0]        idx;
	logic                 is_press;
	logic [2:0]           slot;
	logic [NE-1:0]        pend_next;
	logic                 step;
	logic                 push;
	logic                 pop;
	logic                 out_load;
	logic [6:0]           rd_data;
	hkrd_pkg::fifo_stat_t fstat;

	for (genvar g = 0; g < NS; g++) begin : g_lane
		hkrd_lane u_lane (
			.new_key  (keys_q[g]),
			.old_key  (prev_q[g]),
			.new_keys (keys_q),
			.old_keys (prev_q),
			.shifted  (shift_q),
			.result   (lanes[g])
		);
		assign flags[g]      = lanes[g].press;
		assign flags[NS + g] = lanes[g].release_;
	end

	hkrd_char_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (lanes[slot].ch),
		.pop       (pop),
		.rd_data   (rd_data),
		.stat      (fstat)
	);

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);

	always_comb begin
		idx = '0;
		for (int i = NE - 1; i >= 0; i--) begin
			if (pend_q[i]) idx = IW'(i);
		end
	end

	assign is_press  = (idx < IW'(NS));
	assign slot      = is_press ? idx[2:0] : 3'(idx - IW'(NS));
	assign pend_next = pend_q & (pend_q - NE'(1));
	assign step      = (state_q == ST_WALK) && (pend_q != '0) && (!en_q || slot_free);
	assign push      = step && is_press && (lanes[slot].ch != 7'd0);
	assign pop       = (state_q == ST_READ) && slot_free;
	assign out_load  = (step && en_q) || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			en_q        <= 1'b0;
			prev_q      <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) en_q <= cfg_wr_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= s_tuser ? ST_READ : ST_LOAD;
				end
				ST_LOAD: begin
					pend_q  <= flags;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (pend_q == '0) begin
						prev_q  <= keys_q;
						state_q <= ST_IDLE;
					end else if (step) begin
						pend_q <= pend_next;
					end
				end
				ST_READ: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			shift_q <= (s_tdata[7:0] & hkrd_pkg::SHIFT_MASK) != 8'd0;
			for (int i = 0; i < NS; i++) keys_q[i] <= s_tdata[8*i+8 +: 8];
		end
		if (step && en_q) begin
			out_kind_q  <= is_press ? hkrd_pkg::KIND_PRESS : hkrd_pkg::KIND_RELEASE;
			out_code_q  <= is_press ? keys_q[slot] : prev_q[slot];
			out_char_q  <= 7'd0;
			out_avail_q <= 1'b0;
			out_last_q  <= (pend_next == '0);
		end else if (pop) begin
			out_kind_q  <= hkrd_pkg::KIND_READ;
			out_code_q  <= 8'd0;
			out_char_q  <= fstat.empty ? 7'd0 : rd_data;
			out_avail_q <= !fstat.empty;
			out_last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_avail_q, out_char_q, out_code_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

>>> rtl/hkrd_lane.sv
// One slot lane: press and release detection against the other key set,
// plus ASCII mapping of the new key. Depends on hkrd_pkg.
`default_nettype none
module hkrd_lane (
	input  wire logic          [7:0] new_key,
	input  wire logic          [7:0] old_key,
	input  wire hkrd_pkg::keys_t     new_keys,
	input  wire hkrd_pkg::keys_t     old_keys,
	input  wire logic                shifted,
	output hkrd_pkg::lane_t          result
);

	logic in_old;
	logic in_new;

	always_comb begin
		in_old = 1'b0;
		in_new = 1'b0;
		for (int i = 0; i < hkrd_pkg::NUM_SLOTS; i++) begin
			if (old_keys[i] == new_key) in_old = 1'b1;
			if (new_keys[i] == old_key) in_new = 1'b1;
		end
	end

	assign result.press    = (new_key != 8'd0) && !in_old;
	assign result.release_ = (old_key != 8'd0) && !in_new;
	assign result.ch       = hkrd_pkg::map_key(new_key, shifted);

endmodule
`default_nettype wire

>>> rtl/hkrd_char_fifo.sv
// Circular character FIFO holding DEPTH-1 entries, registered read of the
// head entry. Depends on hkrd_pkg.
`default_nettype none
module hkrd_char_fifo #(
	parameter int DEPTH = hkrd_pkg::FIFO_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic       [6:0] push_data,
	input  wire logic             pop,
	output logic            [6:0] rd_data,
	output hkrd_pkg::fifo_stat_t  stat
);

	localparam int AW = $clog2(DEPTH);

	logic [6:0]    mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] tail_next;
	logic [AW-1:0] head_next;

	assign tail_next = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (tail_next == head_q);

	always_ff @(posedge clk) begin
		if (push && !stat.full) mem[tail_q] <= push_data;
		rd_data <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (push && !stat.full) tail_q <= tail_next;
			if (pop && !stat.empty) head_q <= head_next;
		end
	end

endmodule
`default_nettype wire
